FILE: hdl/bdrl_pkg.sv
`default_nettype none

package bdrl_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_BLANKING_TICKS     = 3'd0;
  localparam logic [2:0] REG_REPEAT_START_DELAY = 3'd1;
  localparam logic [2:0] REG_REPEAT_INTERVAL    = 3'd2;
  localparam logic [2:0] REG_LONG_PRESS_DELAY   = 3'd3;
  localparam logic [2:0] REG_LOWER_THRESHOLD    = 3'd4;
  localparam logic [2:0] REG_UPPER_THRESHOLD    = 3'd5;
  localparam logic [2:0] REG_HYSTERESIS_AMOUNT  = 3'd6;
  localparam logic [2:0] REG_REPEAT_ENABLE      = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ADC_W       = 10;
  localparam int BLANK_W     = 16;
  localparam int HELD_W      = 15;
  localparam int REPEAT_W    = 12;

  localparam logic [BLANK_W-1:0]  BLANK_MAX  = '1;
  localparam logic [HELD_W-1:0]   HELD_MAX   = '1;
  localparam logic [REPEAT_W-1:0] REPEAT_MAX = '1;

  // Unit scale factors: delays count in 100 ms, the repeat interval in 10 ms.
  localparam logic [6:0] DELAY_UNIT    = 7'd100;
  localparam logic [3:0] INTERVAL_UNIT = 4'd10;

  localparam logic [8:0] SCALED_MAX = 9'd255;

  typedef struct packed {
    logic [15:0] blanking_ticks;
    logic [7:0]  repeat_start_delay;
    logic [7:0]  repeat_interval;
    logic [7:0]  long_press_delay;
    logic [7:0]  lower_threshold;
    logic [7:0]  upper_threshold;
    logic [6:0]  hysteresis_amount;
    logic        repeat_enable;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/bdrl_detect.sv
`default_nettype none

module bdrl_detect
  import bdrl_pkg::*;
(
  input  wire cfg_t             cfg,
  input  wire logic             stable_level,
  input  wire logic             pin_level,
  input  wire logic [ADC_W-1:0] adc_sample,
  output logic                  raw_pressed
);

  logic [ADC_W:0]          sum;
  logic [8:0]              scaled_wide;
  logic signed [9:0]       v;
  logic signed [9:0]       h;
  logic signed [9:0]       lo_lim;
  logic signed [9:0]       hi_lim;
  logic                    low_ok;
  logic                    high_ok;
  logic                    analog;

  always_comb begin
    sum         = {1'b0, adc_sample} + (ADC_W+1)'(2);
    scaled_wide = sum[ADC_W:2];
    if (scaled_wide > SCALED_MAX) begin
      scaled_wide = SCALED_MAX;
    end
    v = $signed({1'b0, scaled_wide});

    // The window widens while pressed and narrows while released.
    h = $signed({3'b000, cfg.hysteresis_amount});
    if (!stable_level) begin
      h = -h;
    end
    lo_lim  = $signed({2'b00, cfg.lower_threshold}) - h;
    hi_lim  = $signed({2'b00, cfg.upper_threshold}) + h;
    low_ok  = v >= lo_lim;
    high_ok = v < hi_lim;

    if (cfg.lower_threshold < cfg.upper_threshold) begin
      analog = low_ok && high_ok;
    end else begin
      analog = low_ok || high_ok;
    end

    if (cfg.lower_threshold != cfg.upper_threshold) begin
      raw_pressed = analog;
    end else begin
      raw_pressed = ~pin_level;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/button_debounce_repeat_longpress.sv
`default_nettype none

// Push-button conditioner: one transaction per 1 ms tick carries the active-low
// pin level and a 10-bit converter sample; one result follows per tick with the
// debounced level and press, release and long-press events. With unequal
// thresholds the sample is scaled to 8 bits and run through a window compare
// with hysteresis. The first edge is taken at once, then the input is blanked
// until blanking_ticks ticks have passed since that edge. Throughput is one tick
// per clock cycle while out_ready is held high: a tick is registered at the
// input, and all state updates happen in the single stage to the result
// register. Configuration writes must be made while no tick is in flight.
module button_debounce_repeat_longpress
  import bdrl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   pin_level,
  input  wire logic [ADC_W-1:0]       adc_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        level_pressed,
  output logic                        press_event,
  output logic                        release_event,
  output logic                        long_event
);

  cfg_t cfg;

  logic             s1_valid;
  logic             s1_pin;
  logic [ADC_W-1:0] s1_adc;
  logic             fire;

  logic                stable_level, stable_level_next;
  logic                blanking_active, blanking_active_next;
  logic [BLANK_W-1:0]  blank_elapsed, blank_elapsed_next;
  logic [HELD_W-1:0]   held_elapsed, held_elapsed_next;
  logic [REPEAT_W-1:0] repeat_elapsed, repeat_elapsed_next;
  logic                repeat_started, repeat_started_next;
  logic                long_reported, long_reported_next;
  logic                press_next, release_next, long_next;
  logic                raw;

  logic [HELD_W-1:0]   start_limit;
  logic [HELD_W-1:0]   long_limit;
  logic [REPEAT_W-1:0] interval_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blanking_ticks     <= 16'd100;
      cfg.repeat_start_delay <= '0;
      cfg.repeat_interval    <= '0;
      cfg.long_press_delay   <= '0;
      cfg.lower_threshold    <= '0;
      cfg.upper_threshold    <= '0;
      cfg.hysteresis_amount  <= '0;
      cfg.repeat_enable      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLANKING_TICKS:     cfg.blanking_ticks     <= cfg_data;
        REG_REPEAT_START_DELAY: cfg.repeat_start_delay <= cfg_data[7:0];
        REG_REPEAT_INTERVAL:    cfg.repeat_interval    <= cfg_data[7:0];
        REG_LONG_PRESS_DELAY:   cfg.long_press_delay   <= cfg_data[7:0];
        REG_LOWER_THRESHOLD:    cfg.lower_threshold    <= cfg_data[7:0];
        REG_UPPER_THRESHOLD:    cfg.upper_threshold    <= cfg_data[7:0];
        REG_HYSTERESIS_AMOUNT:  cfg.hysteresis_amount  <= cfg_data[6:0];
        REG_REPEAT_ENABLE:      cfg.repeat_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A tick moves from the input register to the result register when the
  // result register is empty or is being drained in the same cycle.
  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pin <= pin_level;
      s1_adc <= adc_sample;
    end
  end

  bdrl_detect u_detect (
    .cfg          (cfg),
    .stable_level (stable_level),
    .pin_level    (s1_pin),
    .adc_sample   (s1_adc),
    .raw_pressed  (raw)
  );

  assign start_limit    = HELD_W'(cfg.repeat_start_delay) * HELD_W'(DELAY_UNIT);
  assign long_limit     = HELD_W'(cfg.long_press_delay) * HELD_W'(DELAY_UNIT);
  assign interval_limit = REPEAT_W'(cfg.repeat_interval) * REPEAT_W'(INTERVAL_UNIT);

  always_comb begin
    stable_level_next    = stable_level;
    blanking_active_next = blanking_active;
    blank_elapsed_next   = blank_elapsed;
    held_elapsed_next    = held_elapsed;
    repeat_elapsed_next  = repeat_elapsed;
    repeat_started_next  = repeat_started;
    long_reported_next   = long_reported;
    press_next           = 1'b0;
    release_next         = 1'b0;
    long_next            = 1'b0;

    if (blanking_active) begin
      if (blank_elapsed != BLANK_MAX) begin
        blank_elapsed_next = blank_elapsed + 1'b1;
      end
      if (blank_elapsed_next >= cfg.blanking_ticks) begin
        blanking_active_next = 1'b0;
      end
    end
    if (stable_level) begin
      if (held_elapsed != HELD_MAX) begin
        held_elapsed_next = held_elapsed + 1'b1;
      end
      if (repeat_started && repeat_elapsed != REPEAT_MAX) begin
        repeat_elapsed_next = repeat_elapsed + 1'b1;
      end
    end

    if (raw != stable_level && !blanking_active_next) begin
      blanking_active_next = 1'b1;
      blank_elapsed_next   = '0;
      stable_level_next    = raw;
      held_elapsed_next    = '0;
      repeat_elapsed_next  = '0;
      repeat_started_next  = 1'b0;
      if (raw) begin
        press_next = 1'b1;
      end else begin
        long_reported_next = 1'b0;
        release_next       = 1'b1;
      end
    end

    if (stable_level_next) begin
      if (cfg.repeat_interval != '0 && cfg.repeat_enable) begin
        if (!repeat_started_next) begin
          if (held_elapsed_next >= start_limit) begin
            repeat_started_next = 1'b1;
            repeat_elapsed_next = '0;
            press_next          = 1'b1;
          end
        end else if (repeat_elapsed_next >= interval_limit) begin
          repeat_elapsed_next = '0;
          press_next          = 1'b1;
        end
      end
      if (!long_reported_next && cfg.long_press_delay != '0 &&
          held_elapsed_next >= long_limit) begin
        long_reported_next = 1'b1;
        long_next          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level    <= 1'b0;
      blanking_active <= 1'b1;
      blank_elapsed   <= '0;
      held_elapsed    <= '0;
      repeat_elapsed  <= '0;
      repeat_started  <= 1'b0;
      long_reported   <= 1'b0;
    end else if (fire) begin
      stable_level    <= stable_level_next;
      blanking_active <= blanking_active_next;
      blank_elapsed   <= blank_elapsed_next;
      held_elapsed    <= held_elapsed_next;
      repeat_elapsed  <= repeat_elapsed_next;
      repeat_started  <= repeat_started_next;
      long_reported   <= long_reported_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      level_pressed <= stable_level_next;
      press_event   <= press_next;
      release_event <= release_next;
      long_event    <= long_next;
    end
  end

endmodule

`default_nettype wire
